// ===== rtl/ppsc_pkg.sv =====
// Shared types and constants for the polar pose steering controller.
// Holds the arctangent table, fixed-point constants and the iteration record.
// No dependencies.
package ppsc_pkg;

  localparam int SQRT_STEPS = 32;
  localparam int ATAN_LEN   = 24;
  localparam int CW         = 38;   // CORDIC x/y width
  localparam int ZW         = 28;   // angle accumulator width
  localparam int AW         = 30;   // alpha/beta width

  localparam longint PI_Q30      = 64'sd3373259426;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint RAD2DEG_Q16 = 64'sd3754936;

  localparam longint ATAN_Q30 [ATAN_LEN] = '{
    64'sd843314857, 64'sd497837829, 64'sd263043837, 64'sd133525159,
    64'sd67021687,  64'sd33543516,  64'sd16775851,  64'sd8388437,
    64'sd4194283,   64'sd2097149,   64'sd1048576,   64'sd524288,
    64'sd262144,    64'sd131072,    64'sd65536,     64'sd32768,
    64'sd16384,     64'sd8192,      64'sd4096,      64'sd2048,
    64'sd1024,      64'sd512,       64'sd256,       64'sd128
  };

  typedef enum logic [2:0] {
    REG_GAIN_DISTANCE = 3'd0,
    REG_GAIN_ALPHA    = 3'd1,
    REG_GAIN_BETA     = 3'd2,
    REG_STEER_MIN     = 3'd3,
    REG_STEER_MAX     = 3'd4
  } reg_idx_t;

  // Q30 angle rounded half up to f fraction bits
  function automatic longint to_frac(longint q30, int f);
    return (q30 + (64'sd1 <<< (29 - f))) >>> (30 - f);
  endfunction

  function automatic longint atan_frac(int i, int f);
    if (i >= ATAN_LEN) return 64'sd0;
    return to_frac(ATAN_Q30[i], f);
  endfunction

  // state carried through the square-root / CORDIC chain
  typedef struct packed {
    logic [63:0]          n;
    logic [63:0]          r;
    logic                 sh;
    logic                 hold;
    logic signed [CW-1:0] ax;
    logic signed [CW-1:0] ay;
    logic signed [ZW-1:0] az;
    logic signed [CW-1:0] bx;
    logic signed [CW-1:0] by;
    logic signed [ZW-1:0] bz;
    logic signed [18:0]   th;
  } iter_t;

endpackage

// ===== rtl/ppsc_iter_pipe.sv =====
// Iteration chain: one restoring square-root step per stage, with the atan and
// heading-rotation CORDIC steps running alongside in the first stages.
// Depends on ppsc_pkg.
module ppsc_iter_pipe import ppsc_pkg::*; #(
  parameter int FRAC_BITS    = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  logic  in_valid,
  input  iter_t in_data,
  output logic  out_valid,
  output iter_t out_data
);

  iter_t st  [SQRT_STEPS+1];
  logic  vld [SQRT_STEPS+1];

  assign st[0]  = in_data;
  assign vld[0] = in_valid;

  genvar k;
  generate
    for (k = 0; k < SQRT_STEPS; k++) begin : g_stage
      localparam logic [63:0] BIT = 64'd1 << (62 - 2*k);
      localparam logic signed [ZW-1:0] T = ZW'(atan_frac(k, FRAC_BITS));
      iter_t       nxt;
      iter_t       q;
      logic        qv;
      logic [63:0] trial;

      always_comb begin
        nxt   = st[k];
        trial = st[k].r + BIT;
        if (st[k].n >= trial) begin
          nxt.n = st[k].n - trial;
          nxt.r = (st[k].r >> 1) + BIT;
        end else begin
          nxt.r = st[k].r >> 1;
        end
        if (k < CORDIC_STEPS) begin
          if (!st[k].hold) begin
            if (st[k].ay > 0) begin
              nxt.ax = st[k].ax + (st[k].ay >>> k);
              nxt.ay = st[k].ay - (st[k].ax >>> k);
              nxt.az = st[k].az + T;
            end else begin
              nxt.ax = st[k].ax - (st[k].ay >>> k);
              nxt.ay = st[k].ay + (st[k].ax >>> k);
              nxt.az = st[k].az - T;
            end
          end
          if (st[k].bz >= 0) begin
            nxt.bx = st[k].bx + (st[k].by >>> k);
            nxt.by = st[k].by - (st[k].bx >>> k);
            nxt.bz = st[k].bz - T;
          end else begin
            nxt.bx = st[k].bx - (st[k].by >>> k);
            nxt.by = st[k].by + (st[k].bx >>> k);
            nxt.bz = st[k].bz + T;
          end
        end
      end

      always_ff @(posedge clk) begin
        if (rst) qv <= 1'b0;
        else if (en) qv <= vld[k];
        if (en) q <= nxt;
      end

      assign st[k+1]  = q;
      assign vld[k+1] = qv;
    end
  endgenerate

  assign out_data  = st[SQRT_STEPS];
  assign out_valid = vld[SQRT_STEPS];

endmodule

// ===== rtl/polar_pose_steering_controller.sv =====
// Polar pose steering controller: distance, bearing and heading terms to
// velocity and clamped steering commands. Depends on ppsc_pkg, ppsc_iter_pipe.
// Pipeline: 4 front stages, 32 square-root stages and 5 back stages from input
// request to result; the 32-step square-root chain sets the depth.
// Throughput: one request per cycle; the whole pipe holds when the output stalls.
// Reset clears all valid bits and loads the register defaults.
module polar_pose_steering_controller import ppsc_pkg::*; #(
  parameter int FRAC_BITS    = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] cur_x,
  input  logic signed [31:0] cur_y,
  input  logic signed [18:0] cur_heading,
  input  logic signed [31:0] goal_x,
  input  logic signed [31:0] goal_y,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] velocity,
  output logic signed [15:0] steering,
  output logic               steer_clamped,
  output logic               goal_behind
);

  localparam int SW = AW + 18 - (FRAC_BITS - 8);
  localparam int DW = SW + 24;
  localparam logic signed [ZW-1:0] HP   = ZW'(to_frac(HALF_PI_Q30, FRAC_BITS));
  localparam logic signed [ZW-1:0] PI_F = ZW'(to_frac(PI_Q30, FRAC_BITS));
  localparam logic signed [23:0]   RAD2DEG = 24'(RAD2DEG_Q16);
  localparam logic signed [51:0]   VMAX = 52'sd2147483647;
  localparam logic signed [51:0]   VMIN = -VMAX - 52'sd1;

  logic signed [15:0] gain_distance, gain_alpha, gain_beta, steer_min, steer_max;
  logic en;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_distance <= 16'sd256;
      gain_alpha    <= 16'sd26;
      gain_beta     <= -16'sd26;
      steer_min     <= -16'sd7168;
      steer_max     <= 16'sd7168;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GAIN_DISTANCE: gain_distance <= cfg_data;
        REG_GAIN_ALPHA:    gain_alpha    <= cfg_data;
        REG_GAIN_BETA:     gain_beta     <= cfg_data;
        REG_STEER_MIN:     steer_min     <= cfg_data;
        REG_STEER_MAX:     steer_max     <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---- front stages ----
  logic               v1, v2, v3, v4;
  logic signed [32:0] dx1, dy1;
  logic signed [18:0] th1;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= in_valid;
    if (en) begin
      dx1 <= 33'(goal_x) - 33'(cur_x);
      dy1 <= 33'(goal_y) - 33'(cur_y);
      th1 <= cur_heading;
    end
  end

  logic [32:0]         ma, mb;
  logic                sh_c;
  logic signed [ZW-1:0] thz;
  iter_t               init_c, s2, s3, s4, s4_c;
  logic [30:0]         ha2, hb2;
  logic [61:0]         sqa3, sqb3;

  always_comb begin
    ma   = dx1[32] ? 33'(-dx1) : 33'(dx1);
    mb   = dy1[32] ? 33'(-dy1) : 33'(dy1);
    sh_c = ma[32] | ma[31] | mb[32] | mb[31];
    thz  = ZW'(th1);
    init_c      = '0;
    init_c.sh   = sh_c;
    init_c.th   = th1;
    init_c.hold = (dx1 == 33'sd0);
    init_c.ax   = CW'($signed({1'b0, ma}));
    init_c.ay   = dx1[32] ? -CW'(dy1) : CW'(dy1);
    if (dx1 == 33'sd0) begin
      if (dy1 > 33'sd0)      init_c.az = HP;
      else if (dy1 < 33'sd0) init_c.az = -HP;
      else                   init_c.az = '0;
    end
    if (thz > HP) begin
      init_c.bx = -CW'(dx1);
      init_c.by = -CW'(dy1);
      init_c.bz = thz - PI_F;
    end else if (thz < -HP) begin
      init_c.bx = -CW'(dx1);
      init_c.by = -CW'(dy1);
      init_c.bz = thz + PI_F;
    end else begin
      init_c.bx = CW'(dx1);
      init_c.by = CW'(dy1);
      init_c.bz = thz;
    end
  end

  always_comb begin
    s4_c   = s3;
    s4_c.n = 64'(sqa3) + 64'(sqb3);
    s4_c.r = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
    if (en) begin
      s2   <= init_c;
      ha2  <= 31'(ma >> sh_c);
      hb2  <= 31'(mb >> sh_c);
      s3   <= s2;
      sqa3 <= ha2 * ha2;
      sqb3 <= hb2 * hb2;
      s4   <= s4_c;
    end
  end

  iter_t po;
  logic  pv;

  ppsc_iter_pipe #(
    .FRAC_BITS    (FRAC_BITS),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_iter (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v4),
    .in_data   (s4),
    .out_valid (pv),
    .out_data  (po)
  );

  // ---- back stages ----
  logic                  p1, p2, p3, p4;
  logic signed [34:0]    rho1;
  logic signed [AW-1:0]  alpha1, beta1, alpha_c;
  logic                  bh1, bh2, bh3, bh4;
  logic [33:0]           rr_c;
  logic signed [50:0]    vprod2;
  logic signed [AW+15:0] pa2, pb2;
  logic signed [51:0]    vn_c, vs_c;
  logic signed [AW+16:0] ssum_c, sshift_c;
  logic signed [31:0]    vel3, vel4;
  logic signed [SW-1:0]  s3v;
  logic signed [DW-1:0]  dprod4, dr_c;
  logic signed [SW-1:0]  deg_c, hi_c, lo_c;

  always_comb begin
    rr_c    = 34'(po.r[32:0]) << po.sh;
    alpha_c = AW'(po.az) - AW'(po.th);
    vn_c    = bh2 ? -52'(vprod2) : 52'(vprod2);
    vs_c    = vn_c >>> 8;
    ssum_c  = (AW+17)'(pa2) + (AW+17)'(pb2);
    sshift_c = ssum_c >>> (FRAC_BITS - 8);
    dr_c    = (dprod4 + (DW'(1) <<< 23)) >>> 24;
    deg_c   = SW'(dr_c);
    hi_c    = SW'(steer_max);
    lo_c    = SW'(steer_min);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1 <= 1'b0;
      p2 <= 1'b0;
      p3 <= 1'b0;
      p4 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      p1 <= pv;
      p2 <= p1;
      p3 <= p2;
      p4 <= p3;
      out_valid <= p4;
    end
    if (en) begin
      rho1   <= $signed({1'b0, rr_c});
      alpha1 <= alpha_c;
      beta1  <= -AW'(po.th) - alpha_c;
      bh1    <= po.bx[CW-1];

      vprod2 <= gain_distance * rho1;
      pa2    <= gain_alpha * alpha1;
      pb2    <= gain_beta * beta1;
      bh2    <= bh1;

      if (vs_c > VMAX)      vel3 <= 32'sh7fffffff;
      else if (vs_c < VMIN) vel3 <= 32'sh80000000;
      else                  vel3 <= 32'(vs_c);
      s3v <= bh2 ? -SW'(sshift_c) : SW'(sshift_c);
      bh3 <= bh2;

      dprod4 <= s3v * RAD2DEG;
      vel4   <= vel3;
      bh4    <= bh3;

      velocity    <= vel4;
      goal_behind <= bh4;
      if (deg_c > hi_c) begin
        steering      <= steer_max;
        steer_clamped <= 1'b1;
      end else if (deg_c < lo_c) begin
        steering      <= steer_min;
        steer_clamped <= 1'b1;
      end else begin
        steering      <= 16'(deg_c);
        steer_clamped <= 1'b0;
      end
    end
  end

  // clamp flag must match a limit value
  a_clamp_hits_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid && steer_clamped |-> (steering == steer_max || steering == steer_min))
    else $error("clamp flag without limit value");

  a_unclamped_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && !steer_clamped |-> (steering <= steer_max && steering >= steer_min))
    else $error("steering outside limits without clamp flag");

  a_behind_slows: assert property (@(posedge clk) disable iff (rst)
    out_valid && goal_behind && gain_distance >= 16'sd0 |-> velocity <= 32'sd0)
    else $error("positive velocity toward target behind");

endmodule

// ===== test/polar_pose_steering_controller_tb.sv =====
// Testbench for polar_pose_steering_controller: drives pose/goal requests,
// predicts velocity and steering in fixed point, and checks every result.
// Depends on ppsc_pkg and the controller RTL.
`timescale 1ns / 100ps

module polar_pose_steering_controller_tb import ppsc_pkg::*;;

  localparam int FRAC = 16;
  localparam int STEPS = 16;
  localparam int LATENCY = 41;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct {
    logic signed [31:0] vel;
    logic signed [15:0] steer;
    logic clamped;
    logic behind;
  } command_t;

  logic clk = 0, rst = 1;
  logic cfg_we = 0;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic in_valid = 0, out_ready = 0;
  logic in_ready, out_valid;
  logic signed [31:0] cur_x = 0, cur_y = 0, goal_x = 0, goal_y = 0;
  logic signed [18:0] cur_heading = 0;
  logic signed [31:0] velocity;
  logic signed [15:0] steering;
  logic steer_clamped, goal_behind;

  logic signed [15:0] k_dist = 256, k_alpha = 26, k_beta = -26;
  logic signed [15:0] lim_lo = -7168, lim_hi = 7168;
  command_t expected_cmds[$];
  int errors = 0;
  int send_idle = 0, recv_stall = 0;
  longint cycles = 0;

  polar_pose_steering_controller dut (.*);

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic longint shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint tab(int i);
    return (ATAN_Q30[i] + (64'sd1 <<< (29 - FRAC))) >>> (30 - FRAC);
  endfunction

  function automatic longint tab_half();
    return (HALF_PI_Q30 + (64'sd1 <<< (29 - FRAC))) >>> (30 - FRAC);
  endfunction

  function automatic longint int_sqrt(longint unsigned n);
    longint unsigned r = 0, b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else r >>= 1;
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint bearing(longint dx, longint dy);
    longint x, y, z = 0, nx;
    if (dx == 0) return dy > 0 ? tab_half() : (dy < 0 ? -tab_half() : 0);
    x = dx < 0 ? -dx : dx;
    y = dx < 0 ? -dy : dy;
    for (int i = 0; i < STEPS; i++) begin
      if (y > 0) begin
        nx = x + shr(y, i); y = y - shr(x, i); z += tab(i);
      end else begin
        nx = x - shr(y, i); y = y + shr(x, i); z -= tab(i);
      end
      x = nx;
    end
    return z;
  endfunction

  function automatic bit target_behind(longint dx, longint dy, longint th);
    longint x = dx, y = dy, z = th, nx, pi_f;
    pi_f = (PI_Q30 + (64'sd1 <<< (29 - FRAC))) >>> (30 - FRAC);
    if (z > tab_half()) begin
      x = -x; y = -y; z -= pi_f;
    end else if (z < -tab_half()) begin
      x = -x; y = -y; z += pi_f;
    end
    for (int i = 0; i < STEPS; i++) begin
      if (z >= 0) begin
        nx = x + shr(y, i); y = y - shr(x, i); z -= tab(i);
      end else begin
        nx = x - shr(y, i); y = y + shr(x, i); z += tab(i);
      end
      x = nx;
    end
    return x < 0;
  endfunction

  function automatic command_t steer_command(longint cx, longint cy, longint th,
                                            longint gx, longint gy);
    command_t c;
    longint dx, dy, alpha, beta, p, v, s, deg;
    longint unsigned a, b, rho;
    bit sh;
    dx = gx - cx;
    dy = gy - cy;
    a = dx < 0 ? -dx : dx;
    b = dy < 0 ? -dy : dy;
    sh = (a >= 64'd1 << 31) || (b >= 64'd1 << 31);
    a >>= sh;
    b >>= sh;
    rho = int_sqrt(a * a + b * b) << sh;
    alpha = bearing(dx, dy) - th;
    beta = -th - alpha;
    c.behind = target_behind(dx, dy, th);
    p = longint'(k_dist) * longint'(rho);
    if (c.behind) p = -p;
    v = p >>> 8;
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    else if (v < -64'sd2147483648) v = -64'sd2147483648;
    c.vel = v[31:0];
    s = longint'(k_alpha) * alpha + longint'(k_beta) * beta;
    s = s >>> (FRAC - 8);
    if (c.behind) s = -s;
    deg = (s * RAD2DEG_Q16 + (64'sd1 <<< 23)) >>> 24;
    c.clamped = 1;
    if (deg > lim_hi) deg = lim_hi;
    else if (deg < lim_lo) deg = lim_lo;
    else c.clamped = 0;
    c.steer = deg[15:0];
    return c;
  endfunction

  task automatic report(string what, longint got, longint want);
    errors++;
    $display("mismatch %s: got %0d expected %0d", what, got, want);
  endtask

  // receiver side: random stalls, check each result
  always @(posedge clk) begin
    command_t w;
    if (!rst && out_valid && out_ready) begin
      if (expected_cmds.size() == 0) report("unexpected result", 1, 0);
      else begin
        w = expected_cmds.pop_front();
        if (velocity !== w.vel) report("velocity", velocity, w.vel);
        if (steering !== w.steer) report("steering", steering, w.steer);
        if (steer_clamped !== w.clamped) report("steer_clamped", steer_clamped, w.clamped);
        if (goal_behind !== w.behind) report("goal_behind", goal_behind, w.behind);
      end
    end
  end

  always @(negedge clk)
    out_ready <= ($urandom_range(99) >= recv_stall);

  task automatic send_request(logic signed [31:0] cx, logic signed [31:0] cy,
                              logic signed [18:0] th, logic signed [31:0] gx,
                              logic signed [31:0] gy);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    cur_x <= cx; cur_y <= cy; cur_heading <= th; goal_x <= gx; goal_y <= gy;
    expected_cmds.push_back(steer_command(cx, cy, th, gx, gy));
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (expected_cmds.size() != 0) @(negedge clk);
    repeat (LATENCY + 5) @(negedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic signed [15:0] val);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
    @(negedge clk);
    case (idx)
      REG_GAIN_DISTANCE: k_dist = val;
      REG_GAIN_ALPHA: k_alpha = val;
      REG_GAIN_BETA: k_beta = val;
      REG_STEER_MIN: lim_lo = val;
      REG_STEER_MAX: lim_hi = val;
      default: ;
    endcase
  endtask

  task automatic test_directed();
    logic signed [31:0] mx = 32'h7fffffff, mn = 32'h80000000;
    send_request(0, 0, 0, 0, 0);
    send_request(0, 0, 0, 0, 65536);
    send_request(0, 0, 0, 0, -65536);
    send_request(0, 0, 102944, 0, 65536);
    send_request(mn, mn, 0, mx, mx);
    send_request(mx, mx, 0, mn, mn);
    send_request(mn, 0, 205887, mx, 0);
    send_request(0, mx, -205887, 0, mn);
    send_request(0, 0, 19'h3ffff, 65536, 0);
    send_request(0, 0, 19'h40000, 65536, 0);
    send_request(0, 0, 205887, 65536, 0);
    send_request(0, 0, -205887, -65536, 0);
    send_request(0, 0, 0, -65536, 10);
    send_request(0, 0, 102944, 65536, 0);
    send_request(0, 0, 0, 65536, -65536);
    send_request(100, -200, 51472, -300000, 400000);
    drain();
  endtask

  task automatic test_random(int n);
    logic signed [31:0] cx, cy, gx, gy;
    logic signed [18:0] th;
    for (int i = 0; i < n; i++) begin
      cx = $urandom; cy = $urandom; gx = $urandom; gy = $urandom;
      if ($urandom_range(3) != 0) begin
        gx = cx + $signed($urandom_range(2000000)) - 1000000;
        gy = cy + $signed($urandom_range(2000000)) - 1000000;
      end
      th = $urandom_range(3) == 0 ? 19'($urandom) : 19'($signed($urandom_range(411774)) - 205887);
      send_request(cx, cy, th, gx, gy);
    end
  endtask

  task automatic test_config(logic signed [15:0] kd, logic signed [15:0] ka,
                             logic signed [15:0] kb, logic signed [15:0] lo,
                             logic signed [15:0] hi, int n);
    drain();
    write_reg(REG_GAIN_DISTANCE, kd);
    write_reg(REG_GAIN_ALPHA, ka);
    write_reg(REG_GAIN_BETA, kb);
    write_reg(REG_STEER_MIN, lo);
    write_reg(REG_STEER_MAX, hi);
    cfg_we <= 0;
    test_random(n);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    test_directed();
    test_random(334);
    send_idle = 62;
    test_random(150);
    drain();
    send_idle = 0; recv_stall = 62;
    test_config(32767, 32767, -32768, -32768, 32767, 150);
    send_idle = 23; recv_stall = 23;
    test_config(-32768, -32768, 32767, 100, -100, 150);
    send_idle = 62; recv_stall = 0;
    test_config(1, -1, 1, 0, 0, 150);
    send_idle = 0; recv_stall = 0;
    test_config(16'($urandom), 16'($urandom), 16'($urandom), -3000, 3000, 150);
    send_idle = 23; recv_stall = 62;
    test_config(256, 26, -26, -7168, 7168, 150);
    drain();
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule
